### rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, codes and constants shared by the buddy page allocator files.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_CAP        = 4096;
  localparam int PAGE_W          = 12;
  localparam int LINK_W          = 13;
  localparam int ORD_W           = 4;
  localparam int CNT_W           = 13;
  localparam int SZ_W            = 17;
  localparam int ORDER_COUNT_DEF = 11;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ORD_W-1:0]  ord_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam link_t NIL       = LINK_W'(PAGE_CAP);
  localparam cnt_t  COUNT_MAX = CNT_W'(8191);

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_BLOCK     = 2'd1,
    ST_BAD_ORDER    = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    CFG_ZONE_FIRST = 1'b0,
    CFG_ZONE_END   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ASRCH, S_ARD, S_AUNL, S_SPLIT, S_PUSH1, S_PUSH2,
    S_FRD, S_FCHK, S_MSTEP, S_MCHK, S_ADDCHK, S_ADDTEST, S_DONE
  } state_t;

  typedef struct packed {
    logic  meta_we;
    page_t meta_addr;
    logic  meta_flag;
    ord_t  meta_ord;
    logic  nxt_we;
    page_t nxt_addr;
    link_t nxt_data;
    logic  prv_we;
    page_t prv_addr;
    link_t prv_data;
  } mem_wr_t;

  typedef struct packed {
    logic  flag;
    ord_t  ord;
    link_t nxt;
    link_t prv;
  } mem_rd_t;

endpackage

### rtl/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_if
// Command, response and configuration channels of the page allocator.
// ----------------------------------------------------------------------------
interface bpa_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  block_order;
  logic [11:0] page_number;
  logic [12:0] page_count;
  modport source (output valid, action, block_order, page_number, page_count,
                  input ready);
  modport sink (input valid, action, block_order, page_number, page_count,
                output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] granted_page;
  logic [12:0] free_page_total;
  modport source (output valid, status, granted_page, free_page_total,
                  input ready);
  modport sink (input valid, status, granted_page, free_page_total,
                output ready);
endinterface

interface bpa_cfg_if;
  logic        valid;
  logic        ready;
  logic        addr;
  logic [12:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### rtl/bpa_page_mem.sv
// ----------------------------------------------------------------------------
// bpa_page_mem
// Per-page free flag, block order and list links, one read address shared.
// ----------------------------------------------------------------------------
module bpa_page_mem (
  input  logic             clk,
  input  bpa_pkg::mem_wr_t wr,
  input  bpa_pkg::page_t   rd_addr,
  output bpa_pkg::mem_rd_t rd
);
  import bpa_pkg::*;

  logic [ORD_W:0] meta [PAGE_CAP];
  link_t          nxt  [PAGE_CAP];
  link_t          prv  [PAGE_CAP];

  always_ff @(posedge clk) begin
    if (wr.meta_we) begin
      meta[wr.meta_addr] <= {wr.meta_flag, wr.meta_ord};
    end
    if (wr.nxt_we) begin
      nxt[wr.nxt_addr] <= wr.nxt_data;
    end
    if (wr.prv_we) begin
      prv[wr.prv_addr] <= wr.prv_data;
    end
    {rd.flag, rd.ord} <= meta[rd_addr];
    rd.nxt <= nxt[rd_addr];
    rd.prv <= prv[rd_addr];
  end

endmodule

### rtl/buddy_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator: per-order LIFO free lists linked through page memory.
//
// cmd carries one word per request (allocate, free, add range); rsp returns
// one word per request with status, granted page and free page total.
// cfg writes the merge zone bounds; it is always ready.
// Each request runs on one sequencer over the page memory, one read or one
// read-modify-write a cycle. Allocate takes longer with each order searched
// and each split, free with each merge step, add range with each block.
// cmd is not ready while a request is in work. The response register holds a
// finished word while rsp stalls; the next request is accepted meanwhile and
// waits at its end until the register frees.
// After reset the free flags are cleared one page a cycle, all 4096 pages,
// with cmd not ready; cfg writes are taken during that pass.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit #(
  parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  bpa_cmd_if.sink   cmd,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);
  import bpa_pkg::*;

  localparam int             HW   = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam logic [ORD_W:0] OC_X = (ORD_W+1)'(ORDER_COUNT);
  localparam ord_t           OMAX = ORD_W'(ORDER_COUNT - 1);

  state_t  state, state_next;
  act_t    act;
  ord_t    ord, orig, push_ord, aord;
  link_t   pg, endp, hsave, zone_hi;
  page_t   push_pg, bud, granted, clr_cnt, zone_lo, rd_addr;
  status_t status;
  cnt_t    count;
  link_t   head [ORDER_COUNT];

  mem_wr_t wr;
  mem_rd_t rd;

  ord_t            hd_idx;
  link_t           head_rd;
  logic            head_we;
  ord_t            head_wi;
  link_t           head_wd;
  logic [SZ_W-1:0] bx;
  logic            bx_ok, merge, ul_en;
  page_t           ul_p;

  function automatic cnt_t cnt_add(cnt_t c, ord_t o);
    logic [SZ_W:0] s;
    s = (SZ_W+1)'(c) + ((SZ_W+1)'(1) << o);
    return (s > (SZ_W+1)'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(s);
  endfunction

  function automatic cnt_t cnt_sub(cnt_t c, ord_t o);
    logic [SZ_W-1:0] d;
    d = SZ_W'(1) << o;
    return (d > SZ_W'(c)) ? '0 : CNT_W'(SZ_W'(c) - d);
  endfunction

  bpa_page_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign hd_idx  = (state == S_PUSH1) ? push_ord : ord;
  assign head_rd = head[hd_idx[HW-1:0]];
  assign bx      = SZ_W'(pg) ^ (SZ_W'(1) << ord);
  assign bx_ok   = (({1'b0, ord} + 1'b1) < OC_X) && (bx >= SZ_W'(zone_lo)) &&
                   (bx < SZ_W'(zone_hi)) && (bx < SZ_W'(PAGE_CAP));
  assign merge   = rd.flag && (rd.ord == ord);
  assign ul_en   = ((state == S_AUNL) && rd.flag) || ((state == S_MCHK) && merge);
  assign ul_p    = (state == S_AUNL) ? pg[PAGE_W-1:0] : bud;

  always_comb begin
    aord = '0;
    for (int k = 1; k < ORDER_COUNT; k++) begin
      if (((SZ_W'(pg) & ((SZ_W'(1) << k) - SZ_W'(1))) == '0) &&
          ((SZ_W'(pg) + (SZ_W'(1) << k)) <= SZ_W'(endp))) begin
        aord = ORD_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    head_we    = 1'b0;
    head_wi    = '0;
    head_wd    = NIL;
    rd_addr    = pg[PAGE_W-1:0];
    if (ul_en) begin
      wr.meta_we   = 1'b1;
      wr.meta_addr = ul_p;
      wr.meta_flag = 1'b0;
      wr.meta_ord  = rd.ord;
      if (rd.prv < NIL) begin
        wr.nxt_we   = 1'b1;
        wr.nxt_addr = rd.prv[PAGE_W-1:0];
        wr.nxt_data = rd.nxt;
      end else if ({1'b0, rd.ord} < OC_X) begin
        head_we = 1'b1;
        head_wi = rd.ord;
        head_wd = rd.nxt;
      end
      if (rd.nxt < NIL) begin
        wr.prv_we   = 1'b1;
        wr.prv_addr = rd.nxt[PAGE_W-1:0];
        wr.prv_data = rd.prv;
      end
    end
    unique case (state)
      S_CLEAR: begin
        wr.meta_we   = 1'b1;
        wr.meta_addr = clr_cnt;
        wr.meta_flag = 1'b0;
        if (clr_cnt == page_t'(PAGE_CAP - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.valid) begin
          priority case (act_t'(cmd.action))
            ACT_ALLOC: begin
              state_next = ({1'b0, cmd.block_order} < OC_X) ? S_ASRCH : S_DONE;
            end
            ACT_FREE: begin
              if (({1'b0, cmd.block_order} >= OC_X) ||
                  ((SZ_W'(cmd.page_number) + (SZ_W'(1) << cmd.block_order)) >
                   SZ_W'(PAGE_CAP))) begin
                state_next = S_DONE;
              end else begin
                state_next = S_FRD;
              end
            end
            ACT_ADD: begin
              if ((SZ_W'(cmd.page_number) + SZ_W'(cmd.page_count)) >
                  SZ_W'(PAGE_CAP)) begin
                state_next = S_DONE;
              end else begin
                state_next = S_ADDCHK;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ASRCH: begin
        if (head_rd < NIL) begin
          state_next = S_ARD;
        end else if (ord == OMAX) begin
          state_next = S_DONE;
        end
      end
      S_ARD: begin
        state_next = S_AUNL;
      end
      S_AUNL: begin
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        state_next = (ord > orig) ? S_PUSH1 : S_DONE;
      end
      S_PUSH1: begin
        wr.meta_we   = 1'b1;
        wr.meta_addr = push_pg;
        wr.meta_flag = 1'b1;
        wr.meta_ord  = push_ord;
        wr.nxt_we    = 1'b1;
        wr.nxt_addr  = push_pg;
        wr.nxt_data  = head_rd;
        wr.prv_we    = 1'b1;
        wr.prv_addr  = push_pg;
        wr.prv_data  = NIL;
        head_we      = 1'b1;
        head_wi      = push_ord;
        head_wd      = LINK_W'(push_pg);
        if (head_rd < NIL) begin
          state_next = S_PUSH2;
        end else if (act == ACT_ALLOC) begin
          state_next = S_SPLIT;
        end else if (act == ACT_ADD) begin
          state_next = S_ADDCHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PUSH2: begin
        wr.prv_we   = 1'b1;
        wr.prv_addr = hsave[PAGE_W-1:0];
        wr.prv_data = LINK_W'(push_pg);
        if (act == ACT_ALLOC) begin
          state_next = S_SPLIT;
        end else if (act == ACT_ADD) begin
          state_next = S_ADDCHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FRD: begin
        state_next = S_FCHK;
      end
      S_FCHK: begin
        state_next = rd.flag ? S_DONE : S_MSTEP;
      end
      S_MSTEP: begin
        rd_addr    = bx[PAGE_W-1:0];
        state_next = bx_ok ? S_MCHK : S_PUSH1;
      end
      S_MCHK: begin
        state_next = merge ? S_MSTEP : S_PUSH1;
      end
      S_ADDCHK: begin
        state_next = (pg >= endp) ? S_DONE : S_ADDTEST;
      end
      S_ADDTEST: begin
        state_next = rd.flag ? S_ADDCHK : S_PUSH1;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      count     <= '0;
      zone_lo   <= '0;
      zone_hi   <= LINK_W'(PAGE_CAP);
      rsp.valid <= 1'b0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head[i] <= NIL;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg_idx_t'(cfg.addr))
          CFG_ZONE_FIRST: zone_lo <= cfg.data[PAGE_W-1:0];
          CFG_ZONE_END:   zone_hi <= cfg.data;
          default:        zone_lo <= zone_lo;
        endcase
      end
      if (head_we) begin
        head[head_wi[HW-1:0]] <= head_wd;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_PUSH1 && act == ACT_FREE) begin
        count <= cnt_add(count, orig);
      end else if (state == S_PUSH1 && act == ACT_ADD) begin
        count <= cnt_add(count, push_ord);
      end else if (state == S_SPLIT && ord <= orig) begin
        count <= cnt_sub(count, orig);
      end
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        act     <= act_t'(cmd.action);
        ord     <= cmd.block_order;
        orig    <= cmd.block_order;
        pg      <= LINK_W'(cmd.page_number);
        endp    <= LINK_W'(SZ_W'(cmd.page_number) + SZ_W'(cmd.page_count));
        granted <= '0;
        status  <= ST_OK;
        if (act_t'(cmd.action) == ACT_ALLOC || act_t'(cmd.action) == ACT_FREE) begin
          if ({1'b0, cmd.block_order} >= OC_X) begin
            status <= ST_BAD_ORDER;
          end else if (act_t'(cmd.action) == ACT_FREE &&
                       (SZ_W'(cmd.page_number) + (SZ_W'(1) << cmd.block_order)) >
                       SZ_W'(PAGE_CAP)) begin
            status <= ST_OUT_OF_RANGE;
          end
        end else if (act_t'(cmd.action) == ACT_ADD &&
                     (SZ_W'(cmd.page_number) + SZ_W'(cmd.page_count)) >
                     SZ_W'(PAGE_CAP)) begin
          status <= ST_OUT_OF_RANGE;
        end
      end
      S_ASRCH: begin
        if (head_rd < NIL) begin
          pg <= head_rd;
        end else if (ord == OMAX) begin
          status <= ST_NO_BLOCK;
        end else begin
          ord <= ord + 1'b1;
        end
      end
      S_SPLIT: begin
        if (ord > orig) begin
          push_pg  <= PAGE_W'(SZ_W'(pg) + (SZ_W'(1) << (ord - 1'b1)));
          push_ord <= ord - 1'b1;
          ord      <= ord - 1'b1;
        end else begin
          granted <= pg[PAGE_W-1:0];
        end
      end
      S_PUSH1: begin
        hsave <= head_rd;
        if (act == ACT_ADD) begin
          pg <= LINK_W'(SZ_W'(pg) + (SZ_W'(1) << push_ord));
        end
      end
      S_MSTEP: begin
        bud      <= bx[PAGE_W-1:0];
        push_pg  <= pg[PAGE_W-1:0];
        push_ord <= ord;
      end
      S_MCHK: begin
        if (merge) begin
          pg  <= LINK_W'(SZ_W'(pg) & ~(SZ_W'(1) << ord));
          ord <= ord + 1'b1;
        end
      end
      S_ADDCHK: begin
        push_pg  <= pg[PAGE_W-1:0];
        push_ord <= aord;
      end
      S_ADDTEST: begin
        if (rd.flag) begin
          pg <= LINK_W'(SZ_W'(pg) + (SZ_W'(1) << push_ord));
        end
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.status          <= status;
          rsp.granted_page    <= granted;
          rsp.free_page_total <= count;
        end
      end
      default: begin
        hsave <= hsave;
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command taken while a request is in work");

  a_clear_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.ready)
    else $error("command ready during clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable(rsp.status) && $stable(rsp.granted_page) &&
       $stable(rsp.free_page_total)))
    else $error("response word changed while stalled");

  a_merge_buddy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MCHK) |-> (bud != pg[PAGE_W-1:0]))
    else $error("merge buddy equals own block");

endmodule
